// ===== src/ypcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ypcb_pkg
// Types and constants shared by the camera basis controller and datapath.
// ----------------------------------------------------------------------------
package ypcb_pkg;

    localparam int PITCH_LIMIT = 96392;

    typedef enum logic [1:0] {
        ACT_ROTATE = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_SET    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_START_YAW   = 1'b0,
        REG_START_PITCH = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] yaw_delta;
        logic signed [15:0] pitch_delta;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] look_x;
        logic signed [15:0] look_y;
        logic signed [15:0] look_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } out_item_t;

    // datapath operation selected by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_APPLY,
        OP_YAW_SETUP,
        OP_PITCH_SETUP,
        OP_ANGLE,
        OP_X,
        OP_X2,
        OP_HMUL,
        OP_HORNER,
        OP_FINISH,
        OP_PROD,
        OP_TARGET
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       which;   // 0 yaw, 1 pitch
        logic       is_cos;  // horner polynomial select
        logic [2:0] idx;     // horner step or product index
    } cmd_t;

    localparam logic [31:0] SIN_DIV [6] = '{32'd156, 32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
    localparam logic [31:0] COS_DIV [6] = '{32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2};

    // reciprocals of the divisors above: ceil(2^sh / k), exact for 30-bit dividends
    localparam logic [5:0] SIN_SH [6] = '{6'd38, 6'd37, 6'd37, 6'd36, 6'd35, 6'd33};
    localparam logic [5:0] COS_SH [6] = '{6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31};

    localparam logic [31:0] SIN_REC [6] = '{
        32'(((64'd1 << 38) + 64'd155) / 64'd156),
        32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 37) + 64'd71) / 64'd72),
        32'(((64'd1 << 36) + 64'd41) / 64'd42),
        32'(((64'd1 << 35) + 64'd19) / 64'd20),
        32'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam logic [31:0] COS_REC [6] = '{
        32'(((64'd1 << 38) + 64'd131) / 64'd132),
        32'(((64'd1 << 37) + 64'd89) / 64'd90),
        32'(((64'd1 << 36) + 64'd55) / 64'd56),
        32'(((64'd1 << 35) + 64'd29) / 64'd30),
        32'(((64'd1 << 34) + 64'd11) / 64'd12),
        32'(((64'd1 << 31) + 64'd1) / 64'd2)
    };

endpackage

// ===== src/yaw_pitch_camera_basis_top.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_camera_basis_top
// First-person camera: yaw, pitch and position with look/right/up basis.
// ----------------------------------------------------------------------------
// One action is handled at a time, from transfer to result valid: apply,
// then two passes (yaw, pitch) of the shared sine/cosine unit, each with four
// setup steps, twelve Horner steps (each a multiply state then a Horner state)
// and one finish, then four basis products and the target. A new action is
// taken the cycle after the result transfers. The Horner iteration takes the
// largest share of the time.
module yaw_pitch_camera_basis_top
#(
    parameter int SINE_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ypcb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ypcb_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ypcb_pkg::*;

    cmd_t cmd;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'd0);

    ypcb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ypcb_datapath #(.SINE_BITS(SINE_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_data),
        .in_xfer   (in_valid && in_ready),
        .cfg_wr    (cfg_wr),
        .cfg_addr  (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .out_item  (out_data)
    );

endmodule

// ===== src/ypcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ypcb_ctrl
// Sequencer: steps the datapath through one action and hands off the result.
// ----------------------------------------------------------------------------
module ypcb_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ypcb_pkg::cmd_t  cmd
);
    import ypcb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_APPLY, S_SETUP, S_ANGLE, S_X, S_X2, S_HMUL, S_HORNER, S_FINISH,
        S_PROD, S_TARGET, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       which_reg, which_next;
    logic       cos_reg, cos_next;
    logic [2:0] idx_reg, idx_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd.which  = which_reg;
        cmd.is_cos = cos_reg;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_APPLY:  cmd.op = OP_APPLY;
            S_SETUP:  cmd.op = which_reg ? OP_PITCH_SETUP : OP_YAW_SETUP;
            S_ANGLE:  cmd.op = OP_ANGLE;
            S_X:      cmd.op = OP_X;
            S_X2:     cmd.op = OP_X2;
            S_HMUL:   cmd.op = OP_HMUL;
            S_HORNER: cmd.op = OP_HORNER;
            S_FINISH: cmd.op = OP_FINISH;
            S_PROD:   cmd.op = OP_PROD;
            S_TARGET: cmd.op = OP_TARGET;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        which_next = which_reg;
        cos_next   = cos_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_SETUP;
                which_next = 1'b0;
            end
            S_SETUP:  state_next = S_ANGLE;
            S_ANGLE:  state_next = S_X;
            S_X:      state_next = S_X2;
            S_X2:
            begin
                state_next = S_HMUL;
                cos_next   = 1'b0;
                idx_next   = 3'd0;
            end
            S_HMUL:   state_next = S_HORNER;
            S_HORNER:
            begin
                state_next = S_HMUL;
                if (idx_reg == 3'd5)
                begin
                    idx_next = 3'd0;
                    if (cos_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cos_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_FINISH:
            begin
                if (which_reg)
                begin
                    state_next = S_PROD;
                    idx_next   = 3'd0;
                end
                else
                begin
                    which_next = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_PROD:
            begin
                if (idx_reg == 3'd3)
                begin
                    state_next = S_TARGET;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_TARGET: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            which_reg <= 1'b0;
            cos_reg   <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            which_reg <= which_next;
            cos_reg   <= cos_next;
            idx_reg   <= idx_next;
        end
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("out_valid while accepting");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd5) else $error("step index out of range");

endmodule

// ===== src/ypcb_datapath.sv =====
// ----------------------------------------------------------------------------
// ypcb_datapath
// Angle, position and registers; shared sine/cosine unit; basis products.
// ----------------------------------------------------------------------------
module ypcb_datapath
#(
    parameter int SINE_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ypcb_pkg::cmd_t      cmd,
    input  ypcb_pkg::in_item_t  in_item,
    input  logic                in_xfer,
    input  logic                cfg_wr,
    input  logic                cfg_addr,
    input  logic [31:0]         cfg_wdata,
    output logic [31:0]         cfg_rdata,
    output ypcb_pkg::out_item_t out_item
);
    import ypcb_pkg::*;

    localparam int SH = 32 - SINE_BITS;

    // 1/256-degree units to binary angle: 2^21 = 45 * YAW_Q + YAW_R
    localparam logic [15:0] YAW_Q   = 16'((32'd1 << 21) / 32'd45);
    localparam logic [4:0]  YAW_R   = 5'((32'd1 << 21) % 32'd45);
    localparam logic [20:0] YAW_REC = 21'(((32'd1 << 26) + 32'd44) / 32'd45);

    logic [31:0]        start_yaw_reg;
    logic signed [17:0] start_pitch_reg;
    logic [31:0]        yaw_reg;
    logic signed [19:0] pitch_reg;
    logic signed [31:0] pos_reg [3];
    in_item_t           item_reg;

    // sine/cosine unit
    logic [31:0] ang_reg;
    logic [1:0]  quad_reg;
    logic        swap_reg;
    logic [29:0] r_reg;
    logic [30:0] x_reg;
    logic [30:0] x2_reg;
    logic [30:0] t_reg;
    logic [30:0] cv_reg;
    logic [29:0] hq_reg;
    logic signed [31:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [15:0] prod_reg [4];

    // rotate deltas
    logic [15:0]        ymag;
    logic [19:0]        ynum;
    logic [40:0]        yfrac;
    logic [31:0]        ystep;
    logic signed [47:0] pd_full;
    logic signed [23:0] pd;
    logic signed [21:0] psum;
    logic signed [19:0] pclamp;
    logic signed [51:0] pb_full;

    assign ymag    = item_reg.yaw_delta[15] ? 16'(-item_reg.yaw_delta) : item_reg.yaw_delta;
    assign ynum    = {4'd0, ymag} * {15'd0, YAW_R} + 20'd22;
    assign yfrac   = {21'd0, ynum} * {20'd0, YAW_REC};
    assign ystep   = ({16'd0, ymag} * {16'd0, YAW_Q}) + 32'(yfrac >> 26);
    assign pd_full = 48'(item_reg.pitch_delta) * 48'sd74961321 + 48'sd8388608;
    assign pd      = 24'(pd_full >>> 24);
    assign psum    = 22'(pitch_reg) + 22'(pd);
    assign pclamp  = (psum > 22'sd96392) ? 20'sd96392 :
                     (psum < -22'sd96392) ? -20'sd96392 : 20'(psum);
    assign pb_full = 52'(pitch_reg) * 52'sd683565276 + 52'sd32768;

    logic [31:0] ang_src;
    logic [31:0] ang_rnd;
    assign ang_src = cmd.which ? 32'(pb_full >>> 16) : yaw_reg;
    assign ang_rnd = (ang_src + 32'((64'd1 << SH) >> 1)) & ~32'((64'd1 << SH) - 64'd1);

    logic [63:0] x_full, x2_full, hx, sv_full, qfull;
    logic [31:0] rec;
    logic [5:0]  rsh;
    logic [29:0] quo;
    assign x_full  = {34'd0, r_reg} * 64'd3373259426 + 64'd1073741824;
    assign x2_full = {33'd0, x_reg} * {33'd0, x_reg} + 64'd536870912;
    assign hx      = {33'd0, x2_reg} * {33'd0, t_reg} + 64'd536870912;
    assign rec     = cmd.is_cos ? COS_REC[cmd.idx] : SIN_REC[cmd.idx];
    assign rsh     = cmd.is_cos ? COS_SH[cmd.idx] : SIN_SH[cmd.idx];
    assign qfull   = {34'd0, hq_reg} * {32'd0, rec};
    assign quo     = 30'(qfull >> rsh);
    assign sv_full = {33'd0, x_reg} * {33'd0, cv_reg} + 64'd536870912;

    logic signed [31:0] sv, cv, s_o, c_o;
    always_comb
    begin
        sv = $signed({1'b0, 31'(sv_full >> 30)});
        cv = $signed({1'b0, t_reg});
        if (swap_reg)
        begin
            s_o = cv;
            c_o = sv;
        end
        else
        begin
            s_o = sv;
            c_o = cv;
        end
        case (quad_reg)
            2'd0:    begin sv = s_o;  cv = c_o;  end
            2'd1:    begin sv = c_o;  cv = -s_o; end
            2'd2:    begin sv = -s_o; cv = -c_o; end
            default: begin sv = -c_o; cv = s_o;  end
        endcase
    end

    logic signed [31:0] pa, pbv;
    logic signed [63:0] pprod;
    always_comb
    begin
        case (cmd.idx)
            3'd0:    begin pa = cp_reg;  pbv = sy_reg; end
            3'd1:    begin pa = cp_reg;  pbv = cy_reg; end
            3'd2:    begin pa = -sp_reg; pbv = sy_reg; end
            default: begin pa = -sp_reg; pbv = cy_reg; end
        endcase
    end
    assign pprod = 64'(pa) * 64'(pbv) + 64'sd35184372088832;

    function automatic logic signed [15:0] q14(input logic signed [31:0] v);
        logic signed [32:0] s;
        begin
            s = 33'(v) + 33'sd32768;
            q14 = 16'(s >>> 16);
        end
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [32:0] v);
        begin
            if (v > 33'sd2147483647)
                sat = 32'sh7fffffff;
            else if (v < -33'sd2147483648)
                sat = 32'sh80000000;
            else
                sat = 32'(v);
        end
    endfunction

    assign cfg_rdata = cfg_addr ? {{14{start_pitch_reg[17]}}, start_pitch_reg} : start_yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_yaw_reg   <= 32'h80000000;
            start_pitch_reg <= '0;
            yaw_reg         <= 32'h80000000;
            pitch_reg       <= '0;
            pos_reg[0]      <= '0;
            pos_reg[1]      <= '0;
            pos_reg[2]      <= '0;
        end
        else
        begin
            if (cfg_wr && (cfg_addr == REG_START_YAW))
            begin
                start_yaw_reg <= cfg_wdata;
                yaw_reg       <= cfg_wdata;
            end
            if (cfg_wr && (cfg_addr == REG_START_PITCH))
            begin
                start_pitch_reg <= cfg_wdata[17:0];
                pitch_reg <= (cfg_wdata[17:0] > 18'sd96392 && !cfg_wdata[17]) ? 20'sd96392 :
                             ($signed(cfg_wdata[17:0]) < -18'sd96392) ? -20'sd96392 :
                             20'($signed(cfg_wdata[17:0]));
            end
            if (cmd.op == OP_APPLY)
            begin
                case (item_reg.action)
                    ACT_ROTATE:
                    begin
                        yaw_reg   <= item_reg.yaw_delta[15] ? yaw_reg - ystep : yaw_reg + ystep;
                        pitch_reg <= pclamp;
                    end
                    ACT_MOVE:
                    begin
                        pos_reg[0] <= sat(33'(pos_reg[0]) + 33'(item_reg.vec_x));
                        pos_reg[1] <= sat(33'(pos_reg[1]) + 33'(item_reg.vec_y));
                        pos_reg[2] <= sat(33'(pos_reg[2]) + 33'(item_reg.vec_z));
                    end
                    ACT_SET:
                    begin
                        pos_reg[0] <= item_reg.vec_x;
                        pos_reg[1] <= item_reg.vec_y;
                        pos_reg[2] <= item_reg.vec_z;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_item;
        end
        case (cmd.op)
            OP_YAW_SETUP, OP_PITCH_SETUP: ang_reg <= ang_rnd;
            OP_ANGLE:
            begin
                quad_reg <= ang_reg[31:30];
                swap_reg <= ang_reg[29];
                r_reg    <= ang_reg[29] ? 30'((31'd1 << 30) - {1'b0, ang_reg[29:0]})
                                        : ang_reg[29:0];
            end
            OP_X:  x_reg  <= 31'(x_full >> 31);
            OP_X2:
            begin
                x2_reg <= 31'(x2_full >> 30);
                t_reg  <= 31'd1073741824;
            end
            OP_HMUL: hq_reg <= 30'(hx >> 30);
            OP_HORNER:
            begin
                if (cmd.idx == 3'd5)
                begin
                    if (!cmd.is_cos)
                    begin
                        cv_reg <= 31'd1073741824 - {1'b0, quo};
                        t_reg  <= 31'd1073741824;
                    end
                    else
                    begin
                        t_reg <= 31'd1073741824 - {1'b0, quo};
                    end
                end
                else
                begin
                    t_reg <= 31'd1073741824 - {1'b0, quo};
                end
            end
            OP_FINISH:
            begin
                if (cmd.which)
                begin
                    sp_reg <= sv;
                    cp_reg <= cv;
                end
                else
                begin
                    sy_reg <= sv;
                    cy_reg <= cv;
                end
            end
            OP_PROD: prod_reg[cmd.idx[1:0]] <= 16'(pprod >>> 46);
            OP_TARGET:
            begin
                out_item.look_x   <= prod_reg[0];
                out_item.look_y   <= q14(sp_reg);
                out_item.look_z   <= prod_reg[1];
                out_item.right_x  <= q14(-cy_reg);
                out_item.right_y  <= '0;
                out_item.right_z  <= q14(sy_reg);
                out_item.up_x     <= prod_reg[2];
                out_item.up_y     <= q14(cp_reg);
                out_item.up_z     <= prod_reg[3];
                out_item.target_x <= sat(33'(pos_reg[0]) + 33'(prod_reg[0]) * 33'sd4);
                out_item.target_y <= sat(33'(pos_reg[1]) + 33'(q14(sp_reg)) * 33'sd4);
                out_item.target_z <= sat(33'(pos_reg[2]) + 33'(prod_reg[1]) * 33'sd4);
            end
            default: ;
        endcase
    end

    // sine/cosine use cv_reg for the sine polynomial before the final multiply
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_reg <= 20'sd96392) && (pitch_reg >= -20'sd96392))
        else $error("pitch out of range");
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_X2) |-> (x_reg <= 31'd843314857))
        else $error("folded angle too large");
    a_horner_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |-> (t_reg <= 31'd1073741824))
        else $error("cosine above one");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Camera basis unit: random and directed actions against a local predictor.
// Drives rotate, move and set-position actions (plus the unused code) through
// a bursty sender and a stalling receiver, rewrites start yaw and pitch
// between phases, and compares every basis vector and target field.
// ----------------------------------------------------------------------------
module tb_top;
    import ypcb_pkg::*;

    localparam int LATENCY   = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int ANG_BITS  = 16;
    localparam longint Q30   = 64'sd1073741824;
    localparam longint I32LO = -64'sd2147483648;
    localparam longint I32HI = 64'sd2147483647;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    yaw_pitch_camera_basis_top #(.SINE_BITS(ANG_BITS)) dut (.*);

    always #5 clk = ~clk;

    class camera_scoreboard;
        logic [31:0] yaw;
        longint      pitch;
        longint      pos [3];
        out_item_t   pending [$];
        int          errors;
        int          checked;

        function new();
            yaw = 32'h8000_0000;
            pitch = 0;
            foreach (pos[i]) pos[i] = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint fshift(longint v, int n);
            return v >>> n;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] val);
            if (idx == REG_START_YAW)
                yaw = val;
            else
                pitch = clamp(longint'($signed(val[17:0])), -PITCH_LIMIT, PITCH_LIMIT);
        endfunction

        function void sin_cos(logic [31:0] ang, output longint s, output longint c);
            logic [63:0] a, r, x, x2, t, sv, cv, tmp;
            logic [1:0] q;
            bit swap;
            a = {32'b0, ang};
            a = (a + (64'd1 << (31 - ANG_BITS))) & 64'hFFFF_FFFF
                & ~((64'd1 << (32 - ANG_BITS)) - 1);
            q = a[31:30];
            r = a & 64'h3FFF_FFFF;
            swap = r >= (64'd1 << 29);
            if (swap) r = (64'd1 << 30) - r;
            x = (r * 64'd3373259426 + (64'd1 << 30)) >> 31;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            t = Q30;
            for (int i = 0; i < 6; i++)
                t = Q30 - (((x2 * t + (64'd1 << 29)) >> 30) / SIN_DIV[i]);
            sv = (x * t + (64'd1 << 29)) >> 30;
            t = Q30;
            for (int i = 0; i < 6; i++)
                t = Q30 - (((x2 * t + (64'd1 << 29)) >> 30) / COS_DIV[i]);
            cv = t;
            if (swap) begin tmp = sv; sv = cv; cv = tmp; end
            case (q)
                2'd0: begin s = sv;  c = cv;  end
                2'd1: begin s = cv;  c = -longint'(sv); end
                2'd2: begin s = -longint'(sv); c = -longint'(cv); end
                default: begin s = -longint'(cv); c = sv; end
            endcase
        endfunction

        function void note_action(in_item_t it);
            longint sy, cy, sp, cp, pb, yd, pd, v;
            logic [63:0] mag, stp;
            out_item_t o;
            longint lk [3];
            case (action_t'(it.action))
                ACT_ROTATE:
                begin
                    yd = it.yaw_delta;
                    pd = it.pitch_delta;
                    mag = yd < 0 ? -yd : yd;
                    stp = (mag * 64'd16777216 + 64'd180) / 64'd360;
                    if (yd < 0) yaw = yaw - stp[31:0];
                    else yaw = yaw + stp[31:0];
                    pd = fshift(pd * 74961321 + (64'sd1 <<< 23), 24);
                    pitch = clamp(pitch + pd, -PITCH_LIMIT, PITCH_LIMIT);
                end
                ACT_MOVE:
                begin
                    pos[0] = clamp(pos[0] + longint'(it.vec_x), I32LO, I32HI);
                    pos[1] = clamp(pos[1] + longint'(it.vec_y), I32LO, I32HI);
                    pos[2] = clamp(pos[2] + longint'(it.vec_z), I32LO, I32HI);
                end
                ACT_SET:
                begin
                    pos[0] = it.vec_x;
                    pos[1] = it.vec_y;
                    pos[2] = it.vec_z;
                end
                default: ;
            endcase
            sin_cos(yaw, sy, cy);
            pb = fshift(pitch * 683565276 + (64'sd1 <<< 15), 16);
            sin_cos(pb[31:0], sp, cp);
            lk[0] = fshift(cp * sy + (64'sd1 <<< 45), 46);
            lk[1] = fshift(sp + (64'sd1 <<< 15), 16);
            lk[2] = fshift(cp * cy + (64'sd1 <<< 45), 46);
            o.look_x = 16'(lk[0]);
            o.look_y = 16'(lk[1]);
            o.look_z = 16'(lk[2]);
            o.right_x = 16'(fshift(-cy + (64'sd1 <<< 15), 16));
            o.right_y = '0;
            o.right_z = 16'(fshift(sy + (64'sd1 <<< 15), 16));
            o.up_x = 16'(fshift(-sp * sy + (64'sd1 <<< 45), 46));
            o.up_y = 16'(fshift(cp + (64'sd1 <<< 15), 16));
            o.up_z = 16'(fshift(-sp * cy + (64'sd1 <<< 45), 46));
            v = clamp(pos[0] + 4 * lk[0], I32LO, I32HI); o.target_x = 32'(v);
            v = clamp(pos[1] + 4 * lk[1], I32LO, I32HI); o.target_y = 32'(v);
            v = clamp(pos[2] + 4 * lk[2], I32LO, I32HI); o.target_z = 32'(v);
            pending.push_back(o);
        endfunction

        function void field(string nm, longint e, longint a);
            if (e != a) begin
                errors++;
                $display("%0t %s expected %0d actual %0d", $time, nm, e, a);
            end
        endfunction

        function void check_basis(out_item_t a);
            out_item_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result expected none actual %h", $time, a);
                return;
            end
            e = pending.pop_front();
            checked++;
            field("look_x", e.look_x, a.look_x);
            field("look_y", e.look_y, a.look_y);
            field("look_z", e.look_z, a.look_z);
            field("right_x", e.right_x, a.right_x);
            field("right_y", e.right_y, a.right_y);
            field("right_z", e.right_z, a.right_z);
            field("up_x", e.up_x, a.up_x);
            field("up_y", e.up_y, a.up_y);
            field("up_z", e.up_z, a.up_z);
            field("target_x", e.target_x, a.target_x);
            field("target_y", e.target_y, a.target_y);
            field("target_z", e.target_z, a.target_z);
        endfunction
    endclass

    camera_scoreboard sb = new();
    int  accepted_actions = 0;
    int  reg_writes = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    int  stall_mode = 0;

    always @(posedge clk)
    begin
        if (in_valid && in_ready) sb.note_action(in_data);
        if (out_valid && out_ready) sb.check_basis(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("timeout with %0d results pending", sb.pending.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_action(in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        accepted_actions++;
        @(negedge clk);
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function automatic in_item_t rand_action();
        in_item_t it;
        int k;
        it.action = $urandom_range(0, 9) < 6 ? ACT_ROTATE :
                    ($urandom_range(0, 1) ? ACT_MOVE : ACT_SET);
        if ($urandom_range(0, 19) == 0) it.action = ACT_NONE;
        it.vec_x = $urandom; it.vec_y = $urandom; it.vec_z = $urandom;
        k = $urandom_range(0, 3);
        if (k != 0)
        begin
            it.vec_x = $signed(it.vec_x) >>> (8 * k);
            it.vec_y = $signed(it.vec_y) >>> (8 * k);
            it.vec_z = $signed(it.vec_z) >>> (8 * k);
        end
        it.yaw_delta = 16'($urandom);
        it.pitch_delta = 16'($urandom);
        if ($urandom_range(0, 1))
        begin
            it.yaw_delta = $signed(it.yaw_delta) >>> 4;
            it.pitch_delta = $signed(it.pitch_delta) >>> 6;
        end
        return it;
    endfunction

    function automatic in_item_t mk(action_t a, int x, int y, int z, int yd, int pd);
        in_item_t it;
        it.action = a; it.vec_x = x; it.vec_y = y; it.vec_z = z;
        it.yaw_delta = 16'(yd); it.pitch_delta = 16'(pd);
        return it;
    endfunction

    task automatic random_phase(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0)
            begin
                send_action(rand_action());
                burst--; count--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender();
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] yaws [4];
        logic [31:0] pitches [4];
        yaws = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h1234_5678};
        pitches = '{32'h0002_0000, 32'h0001_7888, 32'h0001_FFFF, 32'h0000_1000};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_action(mk(ACT_NONE, 0, 0, 0, 0, 0));
        send_action(mk(ACT_ROTATE, 0, 0, 0, 16'sh7FFF, 16'sh7FFF));
        send_action(mk(ACT_ROTATE, 0, 0, 0, -32768, -32768));
        send_action(mk(ACT_ROTATE, 0, 0, 0, 90 * 256, 0));
        send_action(mk(ACT_ROTATE, 0, 0, 0, -1, 1));
        send_action(mk(ACT_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        send_action(mk(ACT_MOVE, 32'h7FFF_FFFF, 1, -1, 0, 0));
        send_action(mk(ACT_MOVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_action(mk(ACT_MOVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_action(mk(ACT_SET, -1, 0, 65536, 0, 0));
        send_action(mk(ACT_MOVE, -1, -1, -1, 0, 0));
        send_action(mk(ACT_ROTATE, 32'hFFFF_FFFF, -1, -1, 45 * 256, -(30 * 256)));
        send_action(mk(ACT_NONE, 32'h5555_AAAA, 1, 2, 16'sh5555, 16'shAAAA));
        in_valid <= 1'b0;
        drain();

        for (int p = 0; p < 4; p++)
        begin
            reg_write(REG_START_YAW, yaws[p]);
            reg_write(REG_START_PITCH, pitches[p]);
            stall_mode = p % 3;
            send_action(mk(ACT_NONE, 0, 0, 0, 0, 0));
            if (p == 1)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    random_phase(20);
                join
            end
            random_phase(490);
            drain();
        end
        stall_mode = 0;

        $display("%0d actions, %0d results checked, %0d register writes",
                 accepted_actions, sb.checked, reg_writes);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ===== files.f =====
src/ypcb_pkg.sv
src/ypcb_ctrl.sv
src/ypcb_datapath.sv
src/yaw_pitch_camera_basis_top.sv
test/tb_top.sv
